// ----- rtl/core/edit_distance_engine_macros.svh -----
// assertion macros shared by the edit distance engine rtl
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ED_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("edit distance engine check failed");

// next-cycle implication
`define ED_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("edit distance engine check failed");

`endif

// ----- rtl/core/ed_pkg.sv -----
// package with shared types and constants of the edit distance engine
`timescale 1ns / 1ps

package ed_pkg;

    localparam int MAX_LEN_DEF = 64;

    // item mode codes
    localparam logic [1:0] MODE_APPEND_FIRST  = 2'd0;
    localparam logic [1:0] MODE_APPEND_SECOND = 2'd1;
    localparam logic [1:0] MODE_COMPUTE       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL
    } ed_state_t;

    // control of the shared cell unit
    typedef struct packed {
        logic match;
        logic sub_two;
    } ed_cell_ctl_t;

endpackage

// ----- rtl/core/ed_cell_unit.sv -----
// shared add and three-way minimum unit for one dynamic-program cell
`timescale 1ns / 1ps

module ed_cell_unit
    import ed_pkg::*;
#(
    parameter int CW = 8
)
(
    input  ed_cell_ctl_t     ctl,
    input  logic [CW-1:0]    diag,
    input  logic [CW-1:0]    above,
    input  logic [CW-1:0]    left,
    output logic [CW-1:0]    best
);

    logic [CW-1:0] sub_cost;
    logic [CW-1:0] from_diag;
    logic [CW-1:0] from_above;
    logic [CW-1:0] from_left;
    logic [CW-1:0] min_da;

    always_comb
    begin
        if (ctl.match)
        begin
            sub_cost = '0;
        end
        else if (ctl.sub_two)
        begin
            sub_cost = CW'(2);
        end
        else
        begin
            sub_cost = CW'(1);
        end
        from_diag  = diag + sub_cost;
        from_above = above + CW'(1);
        from_left  = left + CW'(1);
        min_da     = (from_above < from_diag) ? from_above : from_diag;
        best       = (from_left < min_da) ? from_left : min_da;
    end

endmodule

// ----- rtl/core/ed_core.sv -----
// sequencer, string and cost-row memories and result registers
`timescale 1ns / 1ps
`include "edit_distance_engine_macros.svh"

module ed_core
    import ed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] mode,
    input  logic [7:0] symbol,
    input  logic       indel_mode,
    output logic       busy,
    output logic       done,
    output logic [7:0] distance,
    output logic       overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(2 * MAX_LEN + 3);
    localparam int SW = (CW > 8) ? CW : 8;

    ed_state_t state_reg, state_next;

    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic [CW-1:0] left_reg, left_next;
    logic          done_reg, done_next;
    logic [7:0]    dist_reg, dist_next;
    logic          ovf_out_reg, ovf_out_next;

    // memories
    logic [7:0]    first_mem  [MAX_LEN];
    logic [7:0]    second_mem [MAX_LEN];
    logic [CW-1:0] cost_mem   [MAX_LEN + 1];
    logic [7:0]    ca_q;
    logic [7:0]    sb_q;
    logic [CW-1:0] above_q;

    logic          fs_we, ss_we, fs_re, ss_re, cr_we, cr_re;
    logic [AW-1:0] fs_waddr, ss_waddr, fs_raddr, ss_raddr;
    logic [LW-1:0] cr_waddr, cr_raddr;
    logic [CW-1:0] cr_wdata;

    logic [LW-1:0] i_dec, j_inc;
    ed_cell_ctl_t  cell_ctl;
    logic [CW-1:0] cell_best;
    logic [CW-1:0] sat_in;
    logic [SW-1:0] sat_wide;
    logic [7:0]    sat_out;

    assign i_dec = i_reg - LW'(1);
    assign j_inc = j_reg + LW'(1);

    assign cell_ctl.match   = (ca_q == sb_q);
    assign cell_ctl.sub_two = indel_mode;

    ed_cell_unit #(
        .CW (CW)
    ) u_cell (
        .ctl   (cell_ctl),
        .diag  (diag_reg),
        .above (above_q),
        .left  (left_reg),
        .best  (cell_best)
    );

    // distance field saturates at 255
    assign sat_in   = (state_reg == ST_CELL) ? cell_best
                                             : (CW'(first_len_reg) + CW'(second_len_reg));
    assign sat_wide = SW'(sat_in);
    assign sat_out  = (sat_wide > SW'(255)) ? 8'hFF : sat_wide[7:0];

    always_comb
    begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        diag_next       = diag_reg;
        left_next       = left_reg;
        done_next       = 1'b0;
        dist_next       = dist_reg;
        ovf_out_next    = ovf_out_reg;
        fs_we           = 1'b0;
        ss_we           = 1'b0;
        fs_re           = 1'b0;
        ss_re           = 1'b0;
        cr_we           = 1'b0;
        cr_re           = 1'b0;
        fs_waddr        = first_len_reg[AW-1:0];
        ss_waddr        = second_len_reg[AW-1:0];
        fs_raddr        = i_dec[AW-1:0];
        ss_raddr        = j_reg[AW-1:0];
        cr_waddr        = j_reg;
        cr_raddr        = j_inc;
        cr_wdata        = cell_best;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_APPEND_FIRST:
                        begin
                            if (first_len_reg < LW'(MAX_LEN))
                            begin
                                fs_we          = 1'b1;
                                first_len_next = first_len_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_APPEND_SECOND:
                        begin
                            if (second_len_reg < LW'(MAX_LEN))
                            begin
                                ss_we           = 1'b1;
                                second_len_next = second_len_reg + LW'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        MODE_COMPUTE:
                        begin
                            if ((first_len_reg == '0) || (second_len_reg == '0))
                            begin
                                // empty string: distance is the other length
                                done_next       = 1'b1;
                                dist_next       = sat_out;
                                ovf_out_next    = ovf_reg;
                                first_len_next  = '0;
                                second_len_next = '0;
                                ovf_next        = 1'b0;
                            end
                            else
                            begin
                                j_next     = '0;
                                state_next = ST_INIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                cr_we    = 1'b1;
                cr_wdata = CW'(j_reg);
                if (j_reg == second_len_reg)
                begin
                    i_next     = LW'(1);
                    state_next = ST_ROW;
                end
                else
                begin
                    j_next = j_inc;
                end
            end
            ST_ROW:
            begin
                // fetch row character and the first cell operands
                fs_re      = 1'b1;
                cr_re      = 1'b1;
                cr_raddr   = LW'(1);
                ss_re      = 1'b1;
                ss_raddr   = '0;
                diag_next  = CW'(i_dec);
                left_next  = CW'(i_reg);
                j_next     = LW'(1);
                state_next = ST_CELL;
            end
            ST_CELL:
            begin
                cr_we     = 1'b1;
                left_next = cell_best;
                diag_next = above_q;
                if (j_reg == second_len_reg)
                begin
                    if (i_reg == first_len_reg)
                    begin
                        done_next       = 1'b1;
                        dist_next       = sat_out;
                        ovf_out_next    = ovf_reg;
                        first_len_next  = '0;
                        second_len_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + LW'(1);
                        state_next = ST_ROW;
                    end
                end
                else
                begin
                    // prefetch operands of the next cell
                    cr_re  = 1'b1;
                    ss_re  = 1'b1;
                    j_next = j_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        dist_reg    <= dist_next;
        ovf_out_reg <= ovf_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            first_mem[fs_waddr] <= symbol;
        end
        if (fs_re)
        begin
            ca_q <= first_mem[fs_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ss_we)
        begin
            second_mem[ss_waddr] <= symbol;
        end
        if (ss_re)
        begin
            sb_q <= second_mem[ss_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cr_we)
        begin
            cost_mem[cr_waddr] <= cr_wdata;
        end
        if (cr_re)
        begin
            above_q <= cost_mem[cr_raddr];
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign distance = dist_reg;
    assign overflow = ovf_out_reg;

    `ED_ASSERT_NOW(a_done_idle, clk, rst_n, done_reg, state_reg == ST_IDLE)
    `ED_ASSERT_NOW(a_cell_col, clk, rst_n, state_reg == ST_CELL,
        (j_reg != '0) && (j_reg <= second_len_reg))
    `ED_ASSERT_NOW(a_cell_row, clk, rst_n, state_reg == ST_CELL,
        (i_reg != '0) && (i_reg <= first_len_reg))
    `ED_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1,
        (first_len_reg <= LW'(MAX_LEN)) && (second_len_reg <= LW'(MAX_LEN)))
    `ED_ASSERT_NEXT(a_compute_busy, clk, rst_n,
        start && !busy && (mode == MODE_COMPUTE) && (first_len_reg != '0)
            && (second_len_reg != '0),
        state_reg == ST_INIT)

endmodule

// ----- rtl/core/edit_distance_engine.sv -----
// top level of the edit distance engine
`timescale 1ns / 1ps
// load beat: busy stays low, no result beat
// compute beat with m, n > 0: busy through the init, row and cell states up to the done strobe;
//   the single cell unit visits one matrix cell per cycle, except while a row is set up
// compute beat with an empty string: done strobe in the next cycle
// result beat holds for one cycle only; the receiver cannot stall it
// rst_n clears lengths, overflow flag, indel mode and the sequencer at once
module edit_distance_engine
    import ed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command beat
    input  logic       start,
    output logic       busy,
    input  logic [1:0] mode,
    input  logic [7:0] symbol,
    // indel mode register write
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    // result beat
    output logic       done,
    output logic [7:0] distance,
    output logic       overflow
);

    // cost model select: 0 levenshtein, 1 insert/delete only
    logic indel_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indel_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            indel_mode_reg <= cfg_wr_data;
        end
    end

    // sequencer walks the matrix row by row through the shared cell unit,
    // keeping one cost row in memory
    ed_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .symbol     (symbol),
        .indel_mode (indel_mode_reg),
        .busy       (busy),
        .done       (done),
        .distance   (distance),
        .overflow   (overflow)
    );

endmodule
